FILE: design/sktl_pkg.sv
`default_nettype none
package sktl_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int VALUE_WORDS = 32;

	localparam int CMD_W   = 3;
	localparam int KEY_W   = 64;
	localparam int WORD_W  = 64;
	localparam int POS_W   = 10;
	localparam int STS_W   = 2;
	localparam int EIDX_W  = 10;

	localparam int IDX_W   = $clog2(MAX_ENTRIES);
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int WW      = (VALUE_WORDS > 1) ? $clog2(VALUE_WORDS) : 1;
	localparam int FILL_W  = $clog2(VALUE_WORDS + 1);
	localparam int VADDR_W = $clog2(MAX_ENTRIES * VALUE_WORDS);

	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WORD  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIND  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GET   = 3'd4;

	localparam logic [STS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STS_W-1:0] ST_OOR  = 2'd2;
	localparam logic [STS_W-1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic accept;
		logic probe;
		logic cmp_step;
		logic miss_load;
		logic word_load;
	} sktl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic search_empty;
		logic probe_eq;
		logic pos_oor;
		logic word_last;
	} sktl_stat_t;

	function automatic logic [EIDX_W-1:0] to_eidx(input logic [IDX_W-1:0] i);
		logic [IDX_W+EIDX_W-1:0] t;
		t = {{EIDX_W{1'b0}}, i};
		return t[EIDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] pos_to_idx(input logic [POS_W-1:0] p);
		logic [IDX_W+POS_W-1:0] t;
		t = {{IDX_W{1'b0}}, p};
		return t[IDX_W-1:0];
	endfunction

	function automatic logic [VADDR_W-1:0] vaddr(input logic [IDX_W-1:0] i,
		input logic [WW-1:0] w);
		logic [VADDR_W-1:0] base;
		base = VADDR_W'(i) * VADDR_W'(VALUE_WORDS);
		return base + VADDR_W'(w);
	endfunction

endpackage
`default_nettype wire

FILE: design/sktl_ctrl.sv
`default_nettype none
module sktl_ctrl import sktl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] cmd,
	input  sktl_stat_t       stat,
	output logic             in_ready,
	output sktl_cmd_t        ctl
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PROBE = 6'b000010,
		S_CMP   = 6'b000100,
		S_MISS  = 6'b001000,
		S_PRE   = 6'b010000,
		S_STRM  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE) && stat.out_free;

	always_comb begin
		state_d       = state_q;
		ctl           = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					ctl.accept = 1'b1;
					if (cmd == CMD_FIND) begin
						state_d = S_PROBE;
					end else if (cmd == CMD_GET && !stat.pos_oor) begin
						state_d = S_PRE;
					end
				end
			end
			S_PROBE: begin
				if (stat.search_empty) begin
					state_d = S_MISS;
				end else begin
					ctl.probe = 1'b1;
					state_d   = S_CMP;
				end
			end
			S_CMP: begin
				ctl.cmp_step = 1'b1;
				state_d      = stat.probe_eq ? S_PRE : S_PROBE;
			end
			S_MISS: begin
				if (stat.out_free) begin
					ctl.miss_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_PRE: begin
				state_d = S_STRM;
			end
			S_STRM: begin
				if (stat.out_free) begin
					ctl.word_load = 1'b1;
					if (stat.word_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/sktl_dp.sv
`default_nettype none
module sktl_dp import sktl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [KEY_W-1:0]  key,
	input  logic [WORD_W-1:0] value_word,
	input  logic [POS_W-1:0]  position,
	input  logic              out_ready,
	input  sktl_cmd_t         ctl,
	output sktl_stat_t        stat,
	output logic              out_valid,
	output logic [STS_W-1:0]  status,
	output logic [EIDX_W-1:0] entry_index,
	output logic [WORD_W-1:0] word_out,
	output logic              last
);

	logic [KEY_W-1:0]  key_mem [MAX_ENTRIES];
	logic [WORD_W-1:0] value_mem [MAX_ENTRIES * VALUE_WORDS];

	logic [CNT_W-1:0]  count_q;
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  lo_q, end_q;
	logic [IDX_W-1:0]  mid_q, hit_idx_q;
	logic [WW-1:0]     w_q;
	logic [KEY_W-1:0]  key_q, key_rd_q;
	logic [WORD_W-1:0] val_rd_q;

	logic              out_valid_q;
	logic [STS_W-1:0]  status_q;
	logic [EIDX_W-1:0] entry_index_q;
	logic [WORD_W-1:0] word_out_q;
	logic              last_q;

	logic [CNT_W-1:0]   diff, mid_full;
	logic [IDX_W-1:0]   mid, cur;
	logic               table_full, count_zero, value_full;
	logic               do_start, do_word;
	logic [WW-1:0]      rd_w;
	logic               res_load, res_last;
	logic [STS_W-1:0]   res_status;
	logic [EIDX_W-1:0]  res_idx;
	logic [WORD_W-1:0]  res_word;

	assign table_full = (count_q >= CNT_W'(MAX_ENTRIES));
	assign count_zero = (count_q == '0);
	assign value_full = (fill_q >= FILL_W'(VALUE_WORDS));
	assign cur        = IDX_W'(count_q - CNT_W'(1));
	assign do_start   = ctl.accept && (cmd == CMD_START) && !table_full;
	assign do_word    = ctl.accept && (cmd == CMD_WORD) && !count_zero && !value_full;

	assign diff     = end_q - lo_q - CNT_W'(1);
	assign mid_full = lo_q + (diff >> 1);
	assign mid      = mid_full[IDX_W-1:0];

	assign stat.out_free     = !out_valid_q || out_ready;
	assign stat.search_empty = (lo_q >= end_q);
	assign stat.probe_eq     = (key_rd_q == key_q);
	assign stat.pos_oor      = ({{CNT_W{1'b0}}, position} >= {{POS_W{1'b0}}, count_q});
	assign stat.word_last    = (w_q == WW'(VALUE_WORDS - 1));

	assign rd_w = ctl.word_load ? (w_q + WW'(1)) : w_q;

	always_ff @(posedge clk) begin
		if (do_start) begin
			key_mem[count_q[IDX_W-1:0]] <= key;
		end
	end

	always_ff @(posedge clk) begin
		key_rd_q <= key_mem[mid];
	end

	always_ff @(posedge clk) begin
		if (do_word) begin
			value_mem[vaddr(cur, fill_q[WW-1:0])] <= value_word;
		end
	end

	always_ff @(posedge clk) begin
		val_rd_q <= value_mem[vaddr(hit_idx_q, rd_w)];
	end

	always_comb begin
		res_load   = 1'b0;
		res_status = ST_OK;
		res_idx    = '0;
		res_word   = '0;
		res_last   = 1'b1;
		if (ctl.accept) begin
			case (cmd)
				CMD_CLEAR: begin
					res_load = 1'b1;
				end
				CMD_START: begin
					res_load = 1'b1;
					if (table_full) begin
						res_status = ST_FULL;
					end else begin
						res_idx = to_eidx(count_q[IDX_W-1:0]);
					end
				end
				CMD_WORD: begin
					res_load = 1'b1;
					if (count_zero) begin
						res_status = ST_FULL;
					end else begin
						res_idx = to_eidx(cur);
						if (value_full) begin
							res_status = ST_FULL;
						end
					end
				end
				CMD_GET: begin
					if (stat.pos_oor) begin
						res_load   = 1'b1;
						res_status = ST_OOR;
						res_idx    = position;
					end
				end
				default: begin
				end
			endcase
		end else if (ctl.miss_load) begin
			res_load   = 1'b1;
			res_status = ST_MISS;
		end else if (ctl.word_load) begin
			res_load = 1'b1;
			res_idx  = to_eidx(hit_idx_q);
			res_word = val_rd_q;
			res_last = stat.word_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.accept && cmd == CMD_CLEAR) begin
				count_q <= '0;
				fill_q  <= '0;
			end else if (do_start) begin
				count_q <= count_q + CNT_W'(1);
				fill_q  <= '0;
			end else if (do_word) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && cmd == CMD_FIND) begin
			lo_q  <= '0;
			end_q <= count_q;
			key_q <= key;
		end
		if (ctl.accept && cmd == CMD_GET && !stat.pos_oor) begin
			hit_idx_q <= pos_to_idx(position);
			w_q       <= '0;
		end
		if (ctl.probe) begin
			mid_q <= mid;
		end
		if (ctl.cmp_step) begin
			if (stat.probe_eq) begin
				hit_idx_q <= mid_q;
				w_q       <= '0;
			end else if (key_rd_q < key_q) begin
				lo_q <= CNT_W'(mid_q) + CNT_W'(1);
			end else begin
				end_q <= CNT_W'(mid_q);
			end
		end
		if (ctl.word_load) begin
			w_q <= w_q + WW'(1);
		end
		if (res_load) begin
			status_q      <= res_status;
			entry_index_q <= res_idx;
			word_out_q    <= res_word;
			last_q        <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = entry_index_q;
	assign word_out    = word_out_q;
	assign last        = last_q;

endmodule
`default_nettype wire

FILE: design/sorted_key_table_lookup_unit.sv
// Sorted key table: entries are filled in order with a start transaction carrying the key
// and then up to 32 value-word transactions, and each fill or clear transaction returns one
// status result. A find runs a binary search over the stored keys, each probe passing
// through a probe state and a compare state because it reads the key memory through its
// registered port; a hit then streams its 32 words at one word per cycle, whenever the
// output is free, after a pre-read state for the value memory; a get by position skips
// the search. The stores come up with undefined contents and only the entry count, word
// fill, output valid flag and controller state are reset.
// Unknown commands are accepted and produce no result.
`default_nettype none
module sorted_key_table_lookup_unit import sktl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [KEY_W-1:0]  key,
	input  logic [WORD_W-1:0] value_word,
	input  logic [POS_W-1:0]  position,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STS_W-1:0]  status,
	output logic [EIDX_W-1:0] entry_index,
	output logic [WORD_W-1:0] word_out,
	output logic              last
);

	sktl_cmd_t  ctl;
	sktl_stat_t stat;

	sktl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.stat     (stat),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	sktl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key         (key),
		.value_word  (value_word),
		.position    (position),
		.out_ready   (out_ready),
		.ctl         (ctl),
		.stat        (stat),
		.out_valid   (out_valid),
		.status      (status),
		.entry_index (entry_index),
		.word_out    (word_out),
		.last        (last)
	);

endmodule
`default_nettype wire

FILE: tb/sv/tb_sorted_key_table_lookup_unit.sv
`timescale 1ns / 1ps
module tb_sorted_key_table_lookup_unit;
	import sktl_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_REQS   = 40;
	localparam int CALM_TAIL     = 60;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 120;
	localparam int MAX_PRINTED   = 100;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [KEY_W-1:0]  k;
		logic [WORD_W-1:0] w;
		logic [POS_W-1:0]  p;
		logic [6:0]        n_res;
	} lookup_req_t;

	typedef struct packed {
		logic [STS_W-1:0]  st;
		logic [EIDX_W-1:0] idx;
		logic [WORD_W-1:0] val;
		logic              lst;
	} lookup_res_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  cmd = '0;
	logic [KEY_W-1:0]  key = '0;
	logic [WORD_W-1:0] value_word = '0;
	logic [POS_W-1:0]  position = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [STS_W-1:0]  status;
	logic [EIDX_W-1:0] entry_index;
	logic [WORD_W-1:0] word_out;
	logic              last;

	logic [KEY_W-1:0]  table_keys  [MAX_ENTRIES];
	logic [WORD_W-1:0] table_words [MAX_ENTRIES*VALUE_WORDS];
	bit                word_held   [MAX_ENTRIES*VALUE_WORDS];
	int                entries_held = 0;
	int                words_filled = 0;

	lookup_req_t pending_requests[$];
	lookup_res_t planned_replies[$];
	lookup_res_t awaited_replies[$];
	lookup_req_t on_bus;
	lookup_res_t due_reply;
	lookup_res_t handed_on;

	int accepted_cnt    = 0;
	int queued_cnt      = 0;
	int total_reqs      = 0;
	int replies_checked = 0;
	int streams_planned = 0;
	int mismatches      = 0;
	int cycle_cnt       = 0;
	int send_gap        = 0;
	int take_gap        = 0;
	bit hold_off        = 1'b0;

	sorted_key_table_lookup_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.key(key),
		.value_word(value_word),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_index(entry_index),
		.word_out(word_out),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [POS_W-1:0] rand_pos();
		logic [31:0] r;
		r = $urandom;
		return r[POS_W-1:0];
	endfunction

	function automatic void plan_reply(input logic [STS_W-1:0] st, input int idx,
		input logic [WORD_W-1:0] val, input bit lst);
		lookup_res_t r;
		logic [31:0] wide_idx;
		wide_idx = idx;
		r.st = st;
		r.idx = wide_idx[EIDX_W-1:0];
		r.val = val;
		r.lst = lst;
		planned_replies = {planned_replies, r};
	endfunction

	function automatic int stream_entry(input int e);
		for (int w = 0; w < VALUE_WORDS; w++) begin
			plan_reply(ST_OK, e, table_words[e*VALUE_WORDS + w], w == VALUE_WORDS - 1);
		end
		streams_planned++;
		return VALUE_WORDS;
	endfunction

	function automatic int search_table(input logic [KEY_W-1:0] k);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = entries_held - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (table_keys[mid] == k) begin
				return mid;
			end
			if (table_keys[mid] < k) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return -1;
	endfunction

	function automatic bit entry_readable(input int e);
		for (int w = 0; w < VALUE_WORDS; w++) begin
			if (!word_held[e*VALUE_WORDS + w]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic int predict_lookup(input lookup_req_t r);
		int hit;
		int n;
		int slot;
		n = 1;
		case (r.op)
		CMD_CLEAR: begin
			entries_held = 0;
			words_filled = 0;
			plan_reply(ST_OK, 0, '0, 1'b1);
		end
		CMD_START: begin
			if (entries_held >= MAX_ENTRIES) begin
				plan_reply(ST_FULL, 0, '0, 1'b1);
			end else begin
				table_keys[entries_held] = r.k;
				entries_held++;
				words_filled = 0;
				plan_reply(ST_OK, entries_held - 1, '0, 1'b1);
			end
		end
		CMD_WORD: begin
			if (entries_held == 0) begin
				plan_reply(ST_FULL, 0, '0, 1'b1);
			end else if (words_filled >= VALUE_WORDS) begin
				plan_reply(ST_FULL, entries_held - 1, '0, 1'b1);
			end else begin
				slot = (entries_held - 1) * VALUE_WORDS + words_filled;
				table_words[slot] = r.w;
				word_held[slot] = 1'b1;
				words_filled++;
				plan_reply(ST_OK, entries_held - 1, '0, 1'b1);
			end
		end
		CMD_FIND: begin
			hit = search_table(r.k);
			if (hit < 0) begin
				plan_reply(ST_MISS, 0, '0, 1'b1);
			end else begin
				n = stream_entry(hit);
			end
		end
		CMD_GET: begin
			if (int'(r.p) >= entries_held) begin
				plan_reply(ST_OOR, int'(r.p), '0, 1'b1);
			end else begin
				n = stream_entry(int'(r.p));
			end
		end
		default: begin
			n = 0;
		end
		endcase
		return n;
	endfunction

	// Lookups that would stream value words never written since reset are dropped here.
	function automatic void queue_request(input logic [CMD_W-1:0] op,
		input logic [KEY_W-1:0] k, input logic [WORD_W-1:0] w, input logic [POS_W-1:0] p);
		lookup_req_t r;
		int hit;
		int n;
		if (op == CMD_FIND) begin
			hit = search_table(k);
			if (hit >= 0 && !entry_readable(hit)) begin
				return;
			end
		end
		if (op == CMD_GET && int'(p) < entries_held && !entry_readable(int'(p))) begin
			return;
		end
		r.op = op;
		r.k = k;
		r.w = w;
		r.p = p;
		r.n_res = '0;
		n = predict_lookup(r);
		r.n_res = n[6:0];
		pending_requests = {pending_requests, r};
		if (n != 0) begin
			queued_cnt++;
		end
	endfunction

	function automatic void fill_entry(input logic [KEY_W-1:0] k, input int n_words);
		queue_request(CMD_START, k, rand64(), rand_pos());
		for (int i = 0; i < n_words; i++) begin
			queue_request(CMD_WORD, rand64(), rand64(), rand_pos());
		end
	endfunction

	function automatic bit may_idle();
		return pending_requests.size() >= CALM_TAIL && (cycle_cnt % 200) >= 50;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < MAX_PRINTED) begin
			$display("[%0t] MISMATCH: %s", $time, msg);
		end
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				for (int i = 0; i < on_bus.n_res; i++) begin
					handed_on = planned_replies.pop_front();
					awaited_replies = {awaited_replies, handed_on};
				end
				accepted_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (may_idle() && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					on_bus = pending_requests.pop_front();
					in_valid <= 1'b1;
					cmd <= on_bus.op;
					key <= on_bus.k;
					value_word <= on_bus.w;
					position <= on_bus.p;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_replies.size() == 0) begin
					flag_mismatch($sformatf(
						"unexpected result transaction: status %0d index %0d word %h last %0b",
						status, entry_index, word_out, last));
				end else begin
					due_reply = awaited_replies.pop_front();
					replies_checked++;
					if (status !== due_reply.st || entry_index !== due_reply.idx ||
						word_out !== due_reply.val || last !== due_reply.lst) begin
						flag_mismatch($sformatf(
							"result %0d: got %0d/%0d/%h/%0b, wanted %0d/%0d/%h/%0b",
							replies_checked, status, entry_index, word_out, last,
							due_reply.st, due_reply.idx, due_reply.val, due_reply.lst));
					end
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				out_ready <= 1'b0;
			end else if (may_idle() && $urandom_range(0, 7) == 0) begin
				take_gap = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// The output is held off for a long stretch so that the block backs up and stalls its input.
	initial begin
		wait (accepted_cnt >= 40);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	end

	always @(negedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d result transactions awaited.",
				cycle_cnt, awaited_replies.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [KEY_W-1:0] next_key;
		logic [KEY_W-1:0] k;
		logic [31:0] c;
		int pick;
		int target;
		int n_words;

		for (int u = int'(CMD_UNUSED_LO); u <= int'(CMD_UNUSED_HI); u++) begin
			c = u;
			queue_request(c[CMD_W-1:0], rand64(), rand64(), rand_pos());
		end
		queue_request(CMD_WORD, rand64(), '1, rand_pos());
		queue_request(CMD_GET, rand64(), rand64(), '1);
		queue_request(CMD_FIND, '0, rand64(), rand_pos());
		queue_request(CMD_START, '0, rand64(), rand_pos());
		queue_request(CMD_WORD, rand64(), '0, rand_pos());
		queue_request(CMD_WORD, rand64(), '1, rand_pos());
		for (int i = 0; i < VALUE_WORDS - 1; i++) begin
			queue_request(CMD_WORD, rand64(), rand64(), rand_pos());
		end
		fill_entry('1, VALUE_WORDS);
		fill_entry(64'h10, 0);
		queue_request(CMD_FIND, '0, rand64(), rand_pos());
		queue_request(CMD_FIND, '1, rand64(), rand_pos());
		queue_request(CMD_FIND, 64'h10, rand64(), rand_pos());
		queue_request(CMD_GET, rand64(), rand64(), 10'd1);
		queue_request(CMD_GET, rand64(), rand64(), 10'd3);
		queue_request(CMD_CLEAR, rand64(), rand64(), rand_pos());
		queue_request(CMD_GET, rand64(), rand64(), '0);
		queue_request(CMD_START, 64'h7, rand64(), rand_pos());
		queue_request(CMD_GET, rand64(), rand64(), '0);
		queue_request(CMD_WORD, rand64(), rand64(), rand_pos());
		queue_request(CMD_FIND, 64'h7, rand64(), rand_pos());

		queue_request(CMD_CLEAR, rand64(), rand64(), rand_pos());
		next_key = rand64() >> 24;
		target = queued_cnt + RANDOM_REQS;
		while (queued_cnt < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				k = $urandom_range(1, 1 << 20);
				next_key = next_key + (k << 8);
				k = ($urandom_range(0, 9) == 0) ? rand64() : next_key;
				n_words = ($urandom_range(0, 4) == 0) ? VALUE_WORDS :
					$urandom_range(0, 3);
				fill_entry(k, n_words);
			end else if (pick < 16) begin
				queue_request(CMD_CLEAR, rand64(), rand64(), rand_pos());
			end else if (pick < 55) begin
				if (entries_held > 0 && $urandom_range(0, 9) < 7) begin
					k = table_keys[$urandom_range(0, entries_held - 1)];
				end else begin
					k = rand64();
				end
				queue_request(CMD_FIND, k, rand64(), rand_pos());
			end else if (pick < 80) begin
				if (entries_held > 0 && $urandom_range(0, 4) != 0) begin
					c = $urandom_range(0, entries_held - 1);
					queue_request(CMD_GET, rand64(), rand64(), c[POS_W-1:0]);
				end else begin
					queue_request(CMD_GET, rand64(), rand64(), rand_pos());
				end
			end else if (pick < 88) begin
				queue_request(CMD_WORD, rand64(), rand64(), rand_pos());
			end else if (pick < 93) begin
				queue_request(CMD_START, rand64(), rand64(), rand_pos());
			end else begin
				c = $urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI));
				queue_request(c[CMD_W-1:0], rand64(), rand64(), rand_pos());
			end
		end

		queue_request(CMD_GET, rand64(), rand64(), '0);
		queue_request(CMD_GET, rand64(), rand64(), '1);
		total_reqs = pending_requests.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_cnt < total_reqs || awaited_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Accepted %0d transactions (%0d with results); checked %0d result transactions.",
			accepted_cnt, queued_cnt, replies_checked);
		$display("Covered %0d value streams, unordered keys, a refused extra value word and a %0d-cycle hold-off.",
			streams_planned, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
design/sktl_pkg.sv
design/sktl_ctrl.sv
design/sktl_dp.sv
design/sorted_key_table_lookup_unit.sv
tb/sv/tb_sorted_key_table_lookup_unit.sv
